// File: design/rrts_pkg.sv
// rrts_pkg: shared types, codes and helper functions for the round-robin task scheduler
// no dependencies; compiled first

package rrts_pkg;

  localparam int unsigned SLOTS    = 32;
  localparam int unsigned TID_W    = 5;
  localparam int unsigned CUR_W    = 6;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned NUM_ST   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE       = 3'd0,
    FN_MAKE_READY   = 3'd1,
    FN_MAKE_UNREADY = 3'd2,
    FN_YIELD        = 3'd3,
    FN_SLEEP        = 3'd4,
    FN_EXIT         = 3'd5,
    FN_START        = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_ILLEGAL = 2'd2,
    STAT_NO_CUR  = 2'd3
  } status_e;

  typedef enum logic [ST_W-1:0] {
    TS_DEAD     = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_BLOCKED  = 3'd4
  } tstate_e;

  // task state kept as bit planes: plane b holds bit b of every slot's state code
  typedef logic [ST_W-1:0][SLOTS-1:0] plane_t;

  // sequencing strobes from the controller to the datapath
  typedef struct packed {
    logic exec;
    logic pick;
    logic finish;
  } ctrl_t;

  // rows: from state, columns: to state
  localparam logic [0:NUM_ST-1][0:NUM_ST-1] TRANS_OK = '{
    5'b11000,
    5'b01100,
    5'b11011,
    5'b11000,
    5'b11000
  };

  function automatic logic legal(logic [ST_W-1:0] from_st, logic [ST_W-1:0] to_st);
    logic ok;
    if (to_st == TS_DEAD) begin
      ok = 1'b1;
    end else if (from_st > 3'd4 || to_st > 3'd4) begin
      ok = 1'b0;
    end else begin
      ok = TRANS_OK[from_st][to_st];
    end
    return ok;
  endfunction

  // priority encoder, lowest set bit wins, zero when empty
  function automatic logic [TID_W-1:0] lowest_set(logic [SLOTS-1:0] m);
    logic [TID_W-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = TID_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ST_W-1:0] st_at(plane_t p, logic [TID_W-1:0] idx);
    logic [ST_W-1:0] r;
    for (int b = 0; b < ST_W; b++) r[b] = p[b][idx];
    return r;
  endfunction

  function automatic plane_t set_st(plane_t p, logic [TID_W-1:0] idx, logic [ST_W-1:0] v);
    plane_t r;
    r = p;
    for (int b = 0; b < ST_W; b++) r[b][idx] = v[b];
    return r;
  endfunction

endpackage

// File: design/rrts_if.sv
// rrts_cmd_if / rrts_res_if: valid-ready channels for scheduler commands and results
// depends on rrts_pkg for field widths

interface rrts_cmd_if;
  import rrts_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0]  task_id;
  logic [TICK_W-1:0] sleep_ticks;

  modport source (output valid, func, task_id, sleep_ticks, input ready);
  modport sink   (input valid, func, task_id, sleep_ticks, output ready);
endinterface

interface rrts_res_if;
  import rrts_pkg::*;
  logic                valid;
  logic                ready;
  logic [TID_W-1:0]    result_task;
  logic [STATUS_W-1:0] status;
  logic                switched;

  modport source (output valid, result_task, status, switched, input ready);
  modport sink   (input valid, result_task, status, switched, output ready);
endinterface

// File: design/rrts_ctrl.sv
// rrts_ctrl: sequencing state machine and handshake control of the scheduler
// depends on rrts_pkg (ctrl_t)

module rrts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rrts_pkg::ctrl_t ctrl_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PICK   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          ctrl_o.exec = 1'b1;
          state_d     = S_PICK;
        end
      end
      S_PICK: begin
        ctrl_o.pick = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        // hold here while an older result is still waiting
        if (!res_valid_q || res_ready_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (ctrl_o.finish) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;

endmodule

// File: design/rrts_datapath.sv
// rrts_datapath: scheduler state, working copy, round-robin pick and result registers
// depends on rrts_pkg (types, transition table, encoder helpers)

module rrts_datapath #(
  parameter int unsigned NUM_TASKS = 32,
  parameter int unsigned IDLE_TASK = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrts_pkg::ctrl_t                ctrl_i,
  input  logic [rrts_pkg::FUNC_W-1:0]    func_i,
  input  logic [rrts_pkg::TID_W-1:0]     task_id_i,
  input  logic [rrts_pkg::TICK_W-1:0]    sleep_ticks_i,
  output logic [rrts_pkg::TID_W-1:0]     result_task_o,
  output logic [rrts_pkg::STATUS_W-1:0]  status_o,
  output logic                           switched_o
);
  import rrts_pkg::*;

  localparam logic [CUR_W-1:0] NONE_ID = CUR_W'(NUM_TASKS);
  localparam logic [TID_W-1:0] IDLE_ID = TID_W'(IDLE_TASK);
  localparam logic [SLOTS-1:0] ONE     = SLOTS'(1);
  localparam logic [SLOTS-1:0] ALL1    = '1;
  localparam logic [CUR_W-1:0] LAST_ID = CUR_W'(SLOTS - 1);

  // committed state
  logic [SLOTS-1:0] mask_q;
  logic [CUR_W-1:0] cur_q;
  plane_t           plane_q;

  // working copy after the command's own effect
  logic [SLOTS-1:0]    wmask_q;
  plane_t              wplane_q;
  logic [STATUS_W-1:0] wstat_q;
  logic                wsched_q, wstart_q, wcreate_q;
  logic [TID_W-1:0]    wcreated_q;
  logic [TID_W-1:0]    nxt_q;

  // result registers
  logic [TID_W-1:0]    res_task_q;
  logic [STATUS_W-1:0] res_stat_q;
  logic                res_sw_q;

  // ---------------- command effect ----------------
  logic [SLOTS-1:0] dead_v;
  logic             free_any, cur_has, tid_ok, mr_go, wr_en;
  logic [TID_W-1:0] free_slot, cur_idx, mr_tgt, wr_idx;
  logic [ST_W-1:0]  mr_st, cur_st, wr_val;
  logic [SLOTS-1:0] emask;
  logic [STATUS_W-1:0] estat;
  logic             esched, estart, ecreate;
  plane_t           eplane;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      dead_v[i] = (i < NUM_TASKS) && (st_at(plane_q, TID_W'(i)) == TS_DEAD);
    end
  end

  assign free_any  = |dead_v;
  assign free_slot = lowest_set(dead_v);
  assign cur_has   = (cur_q != NONE_ID) && !cur_q[CUR_W-1];
  assign cur_idx   = cur_q[TID_W-1:0];
  assign tid_ok    = ({1'b0, task_id_i} < NONE_ID);
  assign cur_st    = st_at(plane_q, cur_idx);

  // one make-ready target per command
  always_comb begin
    case (func_e'(func_i))
      FN_CREATE:     mr_tgt = free_slot;
      FN_MAKE_READY: mr_tgt = task_id_i;
      default:       mr_tgt = IDLE_ID;
    endcase
  end
  assign mr_st = st_at(plane_q, mr_tgt);

  always_comb begin
    emask   = mask_q;
    estat   = STAT_OK;
    esched  = 1'b0;
    estart  = 1'b0;
    ecreate = 1'b0;
    mr_go   = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = cur_idx;
    wr_val  = TS_DEAD;
    case (func_e'(func_i))
      FN_CREATE: begin
        ecreate = 1'b1;
        if (free_any) mr_go = 1'b1;
        else          estat = STAT_NO_SLOT;
      end
      FN_MAKE_READY: begin
        if (tid_ok) mr_go = 1'b1;
        else        estat = STAT_ILLEGAL;
      end
      FN_MAKE_UNREADY: begin
        if (tid_ok) emask = mask_q & ~(ONE << task_id_i);
        else        estat = STAT_ILLEGAL;
      end
      FN_YIELD: esched = 1'b1;
      FN_SLEEP: begin
        if (sleep_ticks_i == '0) begin
          esched = 1'b1;
        end else if (!cur_has) begin
          estat = STAT_NO_CUR;
        end else if (!legal(cur_st, TS_SLEEPING)) begin
          estat = STAT_ILLEGAL;
        end else begin
          wr_en  = 1'b1;
          wr_val = TS_SLEEPING;
          emask  = mask_q & ~(ONE << cur_idx);
          esched = 1'b1;
        end
      end
      FN_EXIT: begin
        if (!cur_has) begin
          estat = STAT_NO_CUR;
        end else begin
          wr_en  = 1'b1;
          wr_val = TS_DEAD;
          emask  = mask_q & ~(ONE << cur_idx);
          esched = 1'b1;
        end
      end
      FN_START: begin
        esched = 1'b1;
        if (cur_q == NONE_ID) begin
          // first start: idle task is made ready when nothing else is
          estart = 1'b1;
          if (mask_q == '0) mr_go = 1'b1;
        end
      end
      default: ;
    endcase
    if (mr_go) begin
      emask = emask | (ONE << mr_tgt);
      if (mr_st != TS_RUNNING) begin
        if (!legal(mr_st, TS_READY)) begin
          estat = STAT_ILLEGAL;
        end else begin
          wr_en  = 1'b1;
          wr_idx = mr_tgt;
          wr_val = TS_READY;
        end
      end
    end
  end

  assign eplane = wr_en ? set_st(plane_q, wr_idx, wr_val) : plane_q;

  // ---------------- round-robin pick ----------------
  logic [SLOTS-1:0] above;
  logic [TID_W-1:0] nxt_d;

  assign above = wmask_q & (ALL1 << (cur_q + CUR_W'(1)));

  always_comb begin
    if (wmask_q == '0) begin
      nxt_d = IDLE_ID;
    end else if (wstart_q || cur_q >= LAST_ID) begin
      nxt_d = lowest_set(wmask_q);
    end else if (above != '0) begin
      nxt_d = lowest_set(above);
    end else begin
      nxt_d = lowest_set(wmask_q);
    end
  end

  // ---------------- reschedule and commit ----------------
  plane_t              fplane;
  logic [CUR_W-1:0]    fcur, final_cur;
  logic [STATUS_W-1:0] fstat;
  logic [ST_W-1:0]     nxt_st, prev_st;
  logic                commit;

  assign nxt_st  = st_at(wplane_q, nxt_q);
  assign prev_st = st_at(wplane_q, cur_idx);

  always_comb begin
    fplane = wplane_q;
    fcur   = cur_q;
    fstat  = wstat_q;
    if (wstat_q == STAT_OK && wsched_q) begin
      if (wstart_q) begin
        if (!legal(nxt_st, TS_RUNNING)) begin
          fstat = STAT_ILLEGAL;
        end else begin
          fplane = set_st(wplane_q, nxt_q, TS_RUNNING);
          fcur   = {1'b0, nxt_q};
        end
      end else if ({1'b0, nxt_q} != cur_q) begin
        // a still-running previous task drops back to ready
        if (cur_has && prev_st == TS_RUNNING) fplane = set_st(fplane, cur_idx, TS_READY);
        if (!legal(nxt_st, TS_RUNNING)) begin
          fstat = STAT_ILLEGAL;
        end else begin
          fplane = set_st(fplane, nxt_q, TS_RUNNING);
          fcur   = {1'b0, nxt_q};
        end
      end
    end
  end

  assign commit    = (fstat == STAT_OK);
  assign final_cur = commit ? fcur : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      cur_q   <= NONE_ID;
      plane_q <= '0;
    end else if (ctrl_i.finish && commit) begin
      mask_q  <= wmask_q;
      cur_q   <= fcur;
      plane_q <= fplane;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      wmask_q    <= emask;
      wplane_q   <= eplane;
      wstat_q    <= estat;
      wsched_q   <= esched;
      wstart_q   <= estart;
      wcreate_q  <= ecreate;
      wcreated_q <= free_slot;
    end
    if (ctrl_i.pick) nxt_q <= nxt_d;
    if (ctrl_i.finish) begin
      if (wcreate_q) begin
        res_task_q <= commit ? wcreated_q : '0;
      end else begin
        res_task_q <= (final_cur != NONE_ID && !final_cur[CUR_W-1]) ?
                      final_cur[TID_W-1:0] : '0;
      end
      res_stat_q <= fstat;
      res_sw_q   <= commit && (fcur != cur_q);
    end
  end

  assign result_task_o = res_task_q;
  assign status_o      = res_stat_q;
  assign switched_o    = res_sw_q;

endmodule

// File: design/round_robin_task_scheduler.sv
// round_robin_task_scheduler: top level, joins the sequencer and the datapath
// depends on rrts_pkg, rrts_if, rrts_ctrl, rrts_datapath
//
//   channel | dir | transfer content                         | handshake
//   --------+-----+------------------------------------------+-------------------
//   cmd_i   | in  | func, task_id, sleep_ticks               | valid/ready
//   res_o   | out | result_task, status, switched            | valid/ready
//
// a command goes through accept (command effect into a working copy), round-robin pick,
// then reschedule, commit and result register load
// a new command is taken only once the previous one has reached the result register
// a stalled result holds the finish step until the result register frees up
// reset is asynchronous, active low; it empties the ready mask, marks every slot
// dead and leaves no task running, with no clearing pass

module round_robin_task_scheduler #(
  parameter int unsigned NUM_TASKS = 32,
  parameter int unsigned IDLE_TASK = 0
) (
  input logic        clk_i,
  input logic        rst_ni,
  rrts_cmd_if.sink   cmd_i,
  rrts_res_if.source res_o
);
  import rrts_pkg::*;

  ctrl_t ctrl;
  logic  cmd_ready, res_valid;

  // sequencer: idle -> pick -> finish, strobes drive the datapath
  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .ctrl_o      (ctrl)
  );

  // ready mask, current task, per-slot state and the result register
  rrts_datapath #(
    .NUM_TASKS (NUM_TASKS),
    .IDLE_TASK (IDLE_TASK)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .func_i        (cmd_i.func),
    .task_id_i     (cmd_i.task_id),
    .sleep_ticks_i (cmd_i.sleep_ticks),
    .result_task_o (res_o.result_task),
    .status_o      (res_o.status),
    .switched_o    (res_o.switched)
  );

  assign cmd_i.ready = cmd_ready;
  assign res_o.valid = res_valid;

endmodule

// File: design/rrts_checker.sv
// rrts_checker: port-level assertions for the scheduler, bound to the top level
// depends on rrts_pkg (status codes) and round_robin_task_scheduler

module rrts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [rrts_pkg::TID_W-1:0]    res_task_i,
  input logic [rrts_pkg::STATUS_W-1:0] res_status_i,
  input logic                          res_switched_i
);
  import rrts_pkg::*;

  // a waiting result keeps its content
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_task_i) &&
      $stable(res_status_i) && $stable(res_switched_i))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("second command taken while busy");

  // a command transfer is followed, past the pick and finish states, by a result on offer, its own one
  // when the result side did not stall, else the older one still waiting
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |-> ##3 res_valid_i)
    else $error("result missing after command");

  // failed commands are rolled back, so no task switch
  a_no_switch_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_switched_i |-> res_status_i == STAT_OK)
    else $error("switch reported on failed command");

  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == STAT_NO_SLOT |-> res_task_i == '0)
    else $error("nonzero task id with no free slot");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_task_i     (res_o.result_task),
  .res_status_i   (res_o.status),
  .res_switched_i (res_o.switched)
);

// File: tb/rrts_sched_checker.sv
// rrts_sched_checker: watches the command and result channels of the task scheduler,
// predicts every result from its own copy of the scheduler state and compares them
// depends on rrts_pkg and rrts_if

module rrts_sched_checker #(
  parameter int unsigned NUM_TASKS = 32,
  parameter int unsigned IDLE_TASK = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrts_cmd_if         cmd_i,
  rrts_res_if         res_i,
  output int unsigned mism_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned switch_cnt_o,
  output int unsigned refused_o
);
  import rrts_pkg::*;

  typedef struct packed {
    logic [TID_W-1:0] task_id;
    status_e          status;
    logic             switched;
  } sched_res_t;

  // predicted scheduler state
  logic [SLOTS-1:0] rdy_mask;
  logic [CUR_W-1:0] cur_task;
  tstate_e          slot_st [SLOTS];

  sched_res_t sched_res_q [$];

  // allowed task state moves, any move to dead is always fine
  function automatic bit move_allowed(tstate_e src, tstate_e dst);
    if (dst == TS_DEAD) return 1'b1;
    case (src)
      TS_DEAD:    return dst == TS_READY;
      TS_READY:   return dst == TS_READY || dst == TS_RUNNING;
      TS_RUNNING: return dst != TS_RUNNING;
      default:    return dst == TS_READY;
    endcase
  endfunction

  function automatic int lowest_ready(logic [SLOTS-1:0] m);
    int r;
    r = 0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = i;
    end
    return r;
  endfunction

  function automatic status_e set_ready(int t);
    rdy_mask[t] = 1'b1;
    if (slot_st[t] != TS_RUNNING) begin
      if (!move_allowed(slot_st[t], TS_READY)) return STAT_ILLEGAL;
      slot_st[t] = TS_READY;
    end
    return STAT_OK;
  endfunction

  // round-robin pick: idle task when nothing is ready, else lowest ready slot above the current one, else wrap around
  function automatic status_e switch_to_next();
    int               nxt;
    int               prev;
    logic [SLOTS-1:0] above;
    prev = int'(cur_task);
    if (rdy_mask == '0) begin
      nxt = IDLE_TASK % SLOTS;
    end else if (prev + 1 >= SLOTS) begin
      nxt = lowest_ready(rdy_mask);
    end else begin
      above = rdy_mask & ~((32'd1 << (prev + 1)) - 32'd1);
      nxt = (above != '0) ? lowest_ready(above) : lowest_ready(rdy_mask);
    end
    if (prev == nxt) return STAT_OK;
    if (prev != NUM_TASKS && prev < SLOTS && slot_st[prev] == TS_RUNNING) begin
      slot_st[prev] = TS_READY;
    end
    if (!move_allowed(slot_st[nxt], TS_RUNNING)) return STAT_ILLEGAL;
    slot_st[nxt] = TS_RUNNING;
    cur_task = CUR_W'(nxt);
    return STAT_OK;
  endfunction

  function automatic sched_res_t schedule_cmd(logic [FUNC_W-1:0] fn, logic [TID_W-1:0] tid,
                                              logic [TICK_W-1:0] ticks);
    logic [SLOTS-1:0] mask_snap;
    logic [CUR_W-1:0] cur_snap;
    tstate_e          st_snap [SLOTS];
    status_e          st;
    sched_res_t       r;
    logic [TID_W-1:0] made;
    bit               is_create;
    bit               found;
    bit               has_cur;
    int               first;
    int               cur;
    mask_snap = rdy_mask;
    cur_snap  = cur_task;
    st_snap   = slot_st;
    st        = STAT_OK;
    made      = '0;
    is_create = 1'b0;
    found     = 1'b0;
    has_cur   = cur_task != NUM_TASKS && cur_task < SLOTS;
    cur       = int'(cur_task);
    case (fn)
      FN_CREATE: begin
        is_create = 1'b1;
        st = STAT_NO_SLOT;
        for (int i = 0; i < NUM_TASKS && i < SLOTS; i++) begin
          if (!found && slot_st[i] == TS_DEAD) begin
            found = 1'b1;
            made  = TID_W'(i);
            st    = set_ready(i);
          end
        end
      end
      FN_MAKE_READY: begin
        if (tid >= NUM_TASKS) st = STAT_ILLEGAL;
        else st = set_ready(int'(tid));
      end
      FN_MAKE_UNREADY: begin
        if (tid >= NUM_TASKS) st = STAT_ILLEGAL;
        else rdy_mask[tid] = 1'b0;
      end
      FN_YIELD: st = switch_to_next();
      FN_SLEEP: begin
        // zero ticks is a plain yield
        if (ticks == '0) begin
          st = switch_to_next();
        end else if (!has_cur) begin
          st = STAT_NO_CUR;
        end else if (!move_allowed(slot_st[cur], TS_SLEEPING)) begin
          st = STAT_ILLEGAL;
        end else begin
          slot_st[cur] = TS_SLEEPING;
          rdy_mask[cur] = 1'b0;
          st = switch_to_next();
        end
      end
      FN_EXIT: begin
        if (!has_cur) begin
          st = STAT_NO_CUR;
        end else begin
          slot_st[cur] = TS_DEAD;
          rdy_mask[cur] = 1'b0;
          st = switch_to_next();
        end
      end
      FN_START: begin
        if (cur_task == NUM_TASKS) begin
          if (rdy_mask != '0) begin
            first = lowest_ready(rdy_mask);
          end else begin
            first = IDLE_TASK % SLOTS;
            st = set_ready(first);
          end
          if (st == STAT_OK) begin
            if (!move_allowed(slot_st[first], TS_RUNNING)) begin
              st = STAT_ILLEGAL;
            end else begin
              slot_st[first] = TS_RUNNING;
              cur_task = CUR_W'(first);
            end
          end
        end else begin
          st = switch_to_next();
        end
      end
      default: ;
    endcase
    // a refused command leaves no trace
    if (st != STAT_OK) begin
      rdy_mask = mask_snap;
      cur_task = cur_snap;
      slot_st  = st_snap;
    end
    has_cur = cur_task != NUM_TASKS && cur_task < SLOTS;
    if (is_create) r.task_id = (st == STAT_OK) ? made : '0;
    else r.task_id = has_cur ? cur_task[TID_W-1:0] : '0;
    r.status   = st;
    r.switched = cur_task != cur_snap;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d", field, checked_o, got,
             want);
    mism_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t want;
    if (!rst_ni) begin
      rdy_mask = '0;
      cur_task = CUR_W'(NUM_TASKS);
      foreach (slot_st[i]) slot_st[i] = TS_DEAD;
      sched_res_q.delete();
      mism_cnt_o   = 0;
      pending_o    <= 0;
      checked_o    <= 0;
      switch_cnt_o <= 0;
      refused_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (sched_res_q.size() == 0) begin
          report_mismatch("unexpected transfer", res_i.result_task, 0);
        end else begin
          want = sched_res_q.pop_front();
          if (res_i.result_task !== want.task_id)
            report_mismatch("result_task", res_i.result_task, want.task_id);
          if (res_i.status !== want.status)
            report_mismatch("status", res_i.status, want.status);
          if (res_i.switched !== want.switched)
            report_mismatch("switched", res_i.switched, want.switched);
          checked_o <= checked_o + 1;
          if (want.switched) switch_cnt_o <= switch_cnt_o + 1;
          if (want.status != STAT_OK) refused_o <= refused_o + 1;
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        sched_res_q.push_back(schedule_cmd(cmd_i.func, cmd_i.task_id, cmd_i.sleep_ticks));
      end
      pending_o <= sched_res_q.size();
    end
  end

endmodule

// File: tb/tb_round_robin_task_scheduler.sv
// tb_round_robin_task_scheduler: stimulus and verdict for the round-robin task scheduler
// depends on rrts_pkg, rrts_if, the scheduler rtl and rrts_sched_checker

module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int unsigned NUM_TASKS = 32;
  localparam int unsigned IDLE_TASK = 0;

  // func code outside the defined set, the block must ignore it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  localparam int unsigned PHASE_CMDS   = 550;    // counted commands per idle profile
  localparam int unsigned LONG_STALL   = 300;    // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES = 20;     // quiet time after the last result
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned CYCLE_LIMIT  = 250000;

  logic clk_i;
  logic rst_ni;

  rrts_cmd_if cmd_if ();
  rrts_res_if res_if ();

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // long receiver hold-off: requested by the stimulus, timed by the receiver
  bit stall_req;
  bit stall_done;

  int unsigned cyc_cnt = 0;
  int unsigned sent_cnt;

  int unsigned mism_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned switches;
  int unsigned refused;

  round_robin_task_scheduler #(
    .NUM_TASKS(NUM_TASKS),
    .IDLE_TASK(IDLE_TASK)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  rrts_sched_checker #(
    .NUM_TASKS(NUM_TASKS),
    .IDLE_TASK(IDLE_TASK)
  ) u_sched_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .res_i       (res_if),
    .mism_cnt_o  (mism_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .switch_cnt_o(switches),
    .refused_o   (refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cyc_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still outstanding", cyc_cnt, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off so the block backs up
  // into its command input while the sender keeps offering
  initial begin
    res_if.ready <= 1'b0;
    stall_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req && !stall_done) begin
        res_if.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // one command transfer, with random idle cycles ahead of it
  // valid stays high after the transfer; the caller lowers it when it stops sending
  task automatic issue_cmd(logic [FUNC_W-1:0] fn, logic [TID_W-1:0] tid,
                           logic [TICK_W-1:0] ticks);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.func        <= fn;
    cmd_if.task_id     <= tid;
    cmd_if.sleep_ticks <= ticks;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // sender pause: nothing offered until every predicted result has come back or DRAIN_LIMIT is reached
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    cmd_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
  endtask

  initial begin
    logic [FUNC_W-1:0] fn;
    logic [TID_W-1:0]  tid;
    logic [TICK_W-1:0] ticks;
    int unsigned       n;
    int unsigned       r;

    rst_ni             <= 1'b0;
    cmd_if.valid       <= 1'b0;
    cmd_if.func        <= FN_CREATE;
    cmd_if.task_id     <= '0;
    cmd_if.sleep_ticks <= '0;
    stall_req          <= 1'b0;
    tx_idle_pct        <= 10;
    rx_idle_pct        <= 74;
    sent_cnt = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk from reset: no running task, idle pickup, wrap-around,
    // sleep with and without ticks, exit of a task that is picked again
    issue_cmd(FN_SLEEP, 5'd0, 16'hFFFF);         // sleep with nothing running
    issue_cmd(FN_EXIT, 5'd0, 16'd0);             // exit with nothing running
    issue_cmd(FN_UNUSED, 5'd31, 16'hFFFF);       // ignored code
    issue_cmd(FN_YIELD, 5'd0, 16'd0);            // empty mask, idle slot still dead
    issue_cmd(FN_START, 5'd0, 16'd0);            // empty mask, idle task made ready
    issue_cmd(FN_CREATE, 5'd0, 16'd0);
    issue_cmd(FN_CREATE, 5'd31, 16'd0);
    issue_cmd(FN_MAKE_READY, 5'd31, 16'd0);      // dead slot straight to ready
    issue_cmd(FN_MAKE_UNREADY, 5'd31, 16'd0);
    issue_cmd(FN_YIELD, 5'd0, 16'd0);
    issue_cmd(FN_SLEEP, 5'd0, 16'd0);            // zero ticks acts as yield
    issue_cmd(FN_SLEEP, 5'd0, 16'd1);            // sleep, then wrap to the lowest
    issue_cmd(FN_MAKE_READY, 5'd2, 16'd0);       // wake the sleeper
    issue_cmd(FN_START, 5'd0, 16'd0);            // start while running acts as yield
    issue_cmd(FN_MAKE_READY, 5'd0, 16'd0);
    issue_cmd(FN_MAKE_UNREADY, 5'd1, 16'd0);
    issue_cmd(FN_MAKE_UNREADY, 5'd2, 16'd0);
    issue_cmd(FN_YIELD, 5'd0, 16'd0);            // wraps back to slot zero
    issue_cmd(FN_MAKE_UNREADY, 5'd0, 16'd0);
    issue_cmd(FN_EXIT, 5'd0, 16'd0);             // same task picked again, stays dead
    issue_cmd(FN_SLEEP, 5'd0, 16'd5);            // dead task cannot sleep
    issue_cmd(FN_CREATE, 5'd0, 16'd0);           // reuses the dead lowest slot
    issue_cmd(FN_YIELD, 5'd0, 16'd0);
    issue_cmd(FN_SLEEP, 5'd31, 16'hFFFF);
    issue_cmd(FN_EXIT, 5'd31, 16'd0);
    wait_results_drained();

    // random part, three idle profiles; creates outweigh exits so the table fills
    // up and the no-free-slot case comes around regularly
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct <= 10;
          rx_idle_pct <= 74;
        end
        1: begin
          tx_idle_pct <= 74;
          rx_idle_pct <= 10;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      n = 0;
      while (n < PHASE_CMDS) begin
        r = $urandom_range(99);
        if (r < 24) fn = FN_CREATE;
        else if (r < 36) fn = FN_MAKE_READY;
        else if (r < 46) fn = FN_MAKE_UNREADY;
        else if (r < 64) fn = FN_YIELD;
        else if (r < 76) fn = FN_SLEEP;
        else if (r < 86) fn = FN_EXIT;
        else if (r < 95) fn = FN_START;
        else fn = FN_UNUSED;
        tid = TID_W'($urandom_range(NUM_TASKS - 1));
        case ($urandom_range(3))
          0:       ticks = '0;
          1:       ticks = 16'hFFFF;
          default: ticks = TICK_W'($urandom_range(65535));
        endcase
        issue_cmd(fn, tid, ticks);
        if (fn != FN_UNUSED) n++;
        if (ph == 0 && n == PHASE_CMDS / 3) stall_req <= 1'b1;
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands under three idle profiles and a %0d-cycle result stall",
             sent_cnt, LONG_STALL);
    $display("compared %0d results: %0d task switches, %0d refused with an error status",
             checked, switches, refused);
    if (mism_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mism_cnt, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/rrts_pkg.sv
design/rrts_if.sv
design/rrts_ctrl.sv
design/rrts_datapath.sv
design/round_robin_task_scheduler.sv
design/rrts_checker.sv
tb/rrts_sched_checker.sv
tb/tb_round_robin_task_scheduler.sv
